[src/div_magic_number_generator_macros.svh]
// Assertion macros used by div_magic_number_generator.sv.
`ifndef DIV_MAGIC_NUMBER_GENERATOR_MACROS_SVH
`define DIV_MAGIC_NUMBER_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define DMG_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Consequent must hold at the clock edge after the antecedent.
`define DMG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DMG_ASSERT(label, clk, rst, cond)
`define DMG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/dmg_pkg.sv]
`timescale 1ns / 1ps

package dmg_pkg;

  localparam int W = 32;

  localparam logic [W-1:0] TWO31   = 32'h8000_0000;
  localparam logic [W-1:0] TWO31M1 = 32'h7FFF_FFFF;
  localparam logic [6:0]   P_START = 7'd31;
  localparam logic [6:0]   P_LIMIT = 7'd64;
  localparam logic [6:0]   WORD    = 7'd32;

  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  // divider request / response
  typedef struct packed {
    logic         start;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
  } div_rsp_t;

endpackage

[src/div_magic_number_generator.sv]
`timescale 1ns / 1ps
// Magic-number generator for division by a 32-bit constant.
// Input stream: s_tdata carries the divisor, s_tuser the mode (0 unsigned,
// 1 signed). Output stream: m_tdata carries magic, add_needed and shift;
// m_tuser flags a bad divisor (zero unsigned; -1, 0 or 1 signed), in which
// case the other fields are zero.
// One transaction is worked at a time; s_tready is high only while idle.
// A valid divisor runs three back-to-back divisions on one shared restoring
// divider (one quotient bit per cycle), then the doubling loop, each step an
// update and then an exactness test, up to 33 steps. A bad divisor goes
// straight to the output stage. s_tready returns together with m_tvalid.
// The result waits in an output register; if the receiver stalls, the next
// item is still accepted and worked, and its result is held back until the
// output register is free.
// Reset (rst, synchronous) returns the sequencer to idle and drops m_tvalid.
`include "div_magic_number_generator_macros.svh"

module div_magic_number_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] divisor
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] magic, [32] add_needed, [38:33] shift, pad
  output logic        m_tuser    // [0] bad_divisor
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV0 = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_DIV2 = 3'd3;
  localparam logic [2:0] ST_STEP = 3'd4;
  localparam logic [2:0] ST_TEST = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam int W = dmg_pkg::W;

  logic [2:0]   state;
  logic         op_r;
  logic         neg;
  logic         bad_r;
  logic         add_r;
  logic [6:0]   p;
  logic [W-1:0] dd;
  logic [W-1:0] nc;
  logic [W-1:0] q1;
  logic [W-1:0] r1;
  logic [W-1:0] q2;
  logic [W-1:0] r2;

  dmg_pkg::div_req_t req;
  dmg_pkg::div_rsp_t rsp;

  logic         accept;
  logic         in_bad;
  logic         in_neg;
  logic [W-1:0] in_ad;
  logic [W-1:0] nc_next;
  logic         bit_u;
  logic         c1;
  logic         c2;
  logic [W-1:0] q1_next;
  logic [W-1:0] r1_next;
  logic [W-1:0] q2_next;
  logic [W-1:0] r2_next;
  logic         add_next;
  logic [W-1:0] delta;
  logic         cont;
  logic         out_free;
  logic [W-1:0] magic_out;
  logic [6:0]   shift_wide;

  dmg_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign in_neg = (s_tuser == dmg_pkg::OP_SIGNED) && s_tdata[W-1];
  assign in_ad  = in_neg ? (~s_tdata + 32'd1) : s_tdata;
  assign in_bad = (s_tdata == '0) ||
                  ((s_tuser == dmg_pkg::OP_SIGNED) &&
                   ((s_tdata == 32'd1) || (s_tdata == '1)));

  // unsigned: ~(-d mod d); signed: 2^31 - 1 + neg - (t mod |d|)
  assign nc_next = (op_r == dmg_pkg::OP_SIGNED) ?
                   (dmg_pkg::TWO31M1 + {31'd0, neg} - rsp.remainder) :
                   ~rsp.remainder;

  always_comb begin
    req.start    = 1'b0;
    req.dividend = dmg_pkg::TWO31;
    req.divisor  = dd;
    unique case (state)
      ST_IDLE: begin
        req.start    = accept && !in_bad;
        req.dividend = (s_tuser == dmg_pkg::OP_SIGNED) ?
                       (dmg_pkg::TWO31 + {31'd0, in_neg}) : (~s_tdata + 32'd1);
        req.divisor  = in_ad;
      end
      ST_DIV0: begin
        req.start    = rsp.done;
        req.dividend = dmg_pkg::TWO31;
        req.divisor  = nc_next;
      end
      ST_DIV1: begin
        req.start    = rsp.done;
        req.dividend = (op_r == dmg_pkg::OP_SIGNED) ? dmg_pkg::TWO31 : dmg_pkg::TWO31M1;
        req.divisor  = dd;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  // one doubling step; unsigned mode carries the extra low one in r2
  assign bit_u   = (op_r == dmg_pkg::OP_UNSIGNED);
  assign c1      = r1 >= (nc - r1);
  assign q1_next = {q1[W-2:0], c1};
  assign r1_next = {r1[W-2:0], 1'b0} - (c1 ? nc : '0);
  assign c2      = (r2 + {31'd0, bit_u}) >= (dd - r2);
  assign q2_next = {q2[W-2:0], c2};
  assign r2_next = {r2[W-2:0], bit_u} - (c2 ? dd : '0);
  assign add_next = add_r ||
                    (bit_u && (c2 ? (q2 >= dmg_pkg::TWO31M1) : (q2 >= dmg_pkg::TWO31)));

  assign delta = dd - {31'd0, bit_u} - r2;
  assign cont  = (p < dmg_pkg::P_LIMIT) && ((q1 < delta) || ((q1 == delta) && (r1 == '0)));

  assign magic_out  = neg ? ~q2 : (q2 + 32'd1);
  assign shift_wide = p - dmg_pkg::WORD;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= in_bad ? ST_FIN : ST_DIV0;
          end
        end
        ST_DIV0: begin
          if (rsp.done) begin
            state <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (rsp.done) begin
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (rsp.done) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          state <= ST_TEST;
        end
        ST_TEST: begin
          state <= cont ? ST_STEP : ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op_r  <= s_tuser;
          neg   <= in_neg;
          bad_r <= in_bad;
          dd    <= in_ad;
          add_r <= 1'b0;
          p     <= dmg_pkg::P_START;
        end
      end
      ST_DIV0: begin
        if (rsp.done) begin
          nc <= nc_next;
        end
      end
      ST_DIV1: begin
        if (rsp.done) begin
          q1 <= rsp.quotient;
          r1 <= rsp.remainder;
        end
      end
      ST_DIV2: begin
        if (rsp.done) begin
          q2 <= rsp.quotient;
          r2 <= rsp.remainder;
        end
      end
      ST_STEP: begin
        q1    <= q1_next;
        r1    <= r1_next;
        q2    <= q2_next;
        r2    <= r2_next;
        add_r <= add_next;
        p     <= p + 7'd1;
      end
      ST_FIN: begin
        if (out_free) begin
          m_tdata[31:0]  <= bad_r ? '0 : magic_out;
          m_tdata[32]    <= bad_r ? 1'b0 : add_r;
          m_tdata[38:33] <= bad_r ? 6'd0 : shift_wide[5:0];
          m_tdata[39]    <= 1'b0;
          m_tuser        <= bad_r;
        end
      end
      default: begin
      end
    endcase
  end

  // divider only finishes while the sequencer waits on it
  `DMG_ASSERT(a_div_done_state, clk, rst,
    !rsp.done || (state == ST_DIV0) || (state == ST_DIV1) || (state == ST_DIV2))
  // doubling loop stays within its bound
  `DMG_ASSERT(a_p_bound, clk, rst,
    (state == ST_IDLE) || (state == ST_FIN) || (p <= dmg_pkg::P_LIMIT))
  // a bad divisor result carries all-zero fields
  `DMG_ASSERT(a_bad_zero, clk, rst,
    !(m_tvalid && m_tuser) || (m_tdata[38:0] == 39'd0))
  // a fresh result only comes out of the final state
  `DMG_ASSERT_NEXT(a_load_from_fin, clk, rst,
    !m_tvalid && (state != ST_FIN), !m_tvalid)

endmodule

[src/dmg_divider.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module dmg_divider (
  input  logic              clk,
  input  logic              rst,
  input  dmg_pkg::div_req_t req,
  output dmg_pkg::div_rsp_t rsp
);

  logic                    busy;
  logic                    done;
  logic [4:0]              cnt;
  logic [dmg_pkg::W-1:0]   rem;
  logic [dmg_pkg::W-1:0]   quo;
  logic [dmg_pkg::W-1:0]   dvs;
  logic [dmg_pkg::W:0]     sh;
  logic [dmg_pkg::W:0]     diff;
  logic                    ge;

  assign sh   = {rem, quo[dmg_pkg::W-1]};
  assign ge   = sh >= {1'b0, dvs};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == 5'd31);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[dmg_pkg::W-1:0] : sh[dmg_pkg::W-1:0];
      quo <= {quo[dmg_pkg::W-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
